// ----- rtl/pfc_pkg.sv -----
// Package for prime_factor_count: state codes, status struct and count constants.
package pfc_pkg;

  // Width of the factor count field and its saturation ceiling.
  localparam int unsigned COUNT_BITS = 5;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = 5'd31;

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CHECK = 3'b010,
    S_DIV   = 3'b100
  } pfc_state_t;

  // Status returned by the serial divider.
  typedef struct packed {
    logic busy;   // division in progress
    logic done;   // one-cycle pulse: quotient and remainder valid
    logic exact;  // remainder is zero (valid with done)
  } pfc_div_stat_t;

endpackage

// ----- rtl/pfc_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
module pfc_div #(
  parameter int unsigned VALUE_BITS = 20,
  parameter int unsigned DIV_BITS   = 11
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [VALUE_BITS-1:0]   dividend,
  input  logic [DIV_BITS-1:0]     divisor,
  output logic [VALUE_BITS-1:0]   quotient,
  output pfc_pkg::pfc_div_stat_t  stat
);
  import pfc_pkg::*;

  localparam int unsigned CW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] q_r, q_nxt;
  logic [DIV_BITS-1:0]   p_r, p_nxt;
  logic [DIV_BITS:0]     trial;
  logic [DIV_BITS+1:0]   diff;
  logic                  ge;

  // Bring down the next dividend bit and try the subtraction.
  assign trial = {p_r, q_r[VALUE_BITS-1]};
  assign diff  = {1'b0, trial} - {2'b00, divisor};
  assign ge    = ~diff[DIV_BITS+1];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    p_nxt    = p_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(VALUE_BITS - 1);
      q_nxt    = dividend;
      p_nxt    = '0;
    end else if (busy_r) begin
      q_nxt = {q_r[VALUE_BITS-2:0], ge};
      p_nxt = ge ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    p_r   <= p_nxt;
  end

  assign quotient   = q_r;
  assign stat.busy  = busy_r;
  assign stat.done  = done_r;
  assign stat.exact = done_r && (p_r == '0);

endmodule

// ----- rtl/prime_factor_count.sv -----
// Top level of prime_factor_count: counts prime factors with multiplicity.
//
// Usage:
//   Input channel  in_valid / in_ready / in_value: one unsigned request per item.
//   Output channel out_valid / out_ready / out_factor_count: one result per
//   request, in order. Inputs 0 and 1 give 0; a prime gives 1.
// Operation:
//   Trial divisors 2, 3, 4, ... are applied to a running remainder by a
//   bit-serial divider. Each divisor is removed as often as it divides; the
//   walk stops when divisor squared exceeds the remainder, and a remainder
//   above one then counts as one more prime.
// Work per item:
//   Each division is followed by a pass through the check state; the number
//   of divisions per item is at most about sqrt(value) plus the count.
//   One request is processed at a time.
// Reset: the block returns to idle with no result pending.
// Stall: a finished result waits in the output register; a later result
//   holds in the check stage until out_ready takes the earlier one.
module prime_factor_count #(
  parameter int unsigned VALUE_BITS = 20
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [VALUE_BITS-1:0]            in_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [pfc_pkg::COUNT_BITS-1:0]   out_factor_count
);
  import pfc_pkg::*;

  // Divisor never exceeds about 2^(VALUE_BITS/2) + 1.
  localparam int unsigned DIV_BITS = (VALUE_BITS + 1) / 2 + 1;
  // Running square of the divisor, with headroom for the final increment.
  localparam int unsigned SQ_BITS  = VALUE_BITS + 2;

  pfc_state_t            state_r, state_nxt;
  logic [VALUE_BITS-1:0] rem_r, rem_nxt;
  logic [DIV_BITS-1:0]   div_r, div_nxt;
  logic [SQ_BITS-1:0]    sq_r, sq_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [COUNT_BITS-1:0] out_count_r, out_count_nxt;

  logic                  div_start;
  logic [VALUE_BITS-1:0] div_quot;
  pfc_div_stat_t         div_stat;
  logic                  sq_over;
  logic                  rem_gt1;
  logic                  out_free;
  logic [COUNT_BITS-1:0] count_inc;
  logic [COUNT_BITS-1:0] final_count;

  pfc_div #(
    .VALUE_BITS(VALUE_BITS),
    .DIV_BITS  (DIV_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rem_r),
    .divisor  (div_r),
    .quotient (div_quot),
    .stat     (div_stat)
  );

  // Stop test: divisor squared above the remainder.
  assign sq_over   = sq_r > {2'b00, rem_r};
  assign rem_gt1   = |rem_r[VALUE_BITS-1:1];
  assign out_free  = !out_valid_r || out_ready;
  // Saturating increment of the running count.
  assign count_inc = (count_r == COUNT_MAX) ? count_r : count_r + 1'b1;
  assign final_count = rem_gt1 ? count_inc : count_r;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    sq_nxt        = sq_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_count_nxt = out_count_r;
    div_start     = 1'b0;

    // Drop the result once the receiver takes it.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        // Load a new request and restart the divisor walk at two.
        if (in_valid) begin
          rem_nxt   = in_value;
          div_nxt   = DIV_BITS'(2);
          sq_nxt    = SQ_BITS'(4);
          count_nxt = '0;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sq_over) begin
          // Finish: hold until the output register is free.
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_count_nxt = final_count;
            state_nxt     = S_IDLE;
          end
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          if (div_stat.exact) begin
            // Divisor divides: take the quotient, keep the same divisor.
            rem_nxt   = div_quot;
            count_nxt = count_inc;
          end else begin
            // Advance the divisor; (d+1)^2 = d^2 + 2d + 1.
            div_nxt = div_r + 1'b1;
            sq_nxt  = sq_r + SQ_BITS'({div_r, 1'b1});
          end
          state_nxt = S_CHECK;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rem_r       <= rem_nxt;
    div_r       <= div_nxt;
    sq_r        <= sq_nxt;
    count_r     <= count_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_factor_count = out_count_r;

  // The running square tracks the divisor exactly.
  a_square_track: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> (sq_r == SQ_BITS'(div_r) * SQ_BITS'(div_r)))
    else $error("running square does not match divisor");

  // The divisor never drops below two during the walk.
  a_div_min: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK || state_r == S_DIV) |-> (div_r >= DIV_BITS'(2)))
    else $error("trial divisor below two");

  // An accepted request loads the remainder and enters the check stage.
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_CHECK && rem_r == $past(in_value)))
    else $error("request not loaded");

  // The divider only reports completion while the sequencer waits on it.
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_DIV))
    else $error("divider done outside divide state");

endmodule

// ----- tb/tb_prime_factor_count.sv -----
// Testbench for prime_factor_count: checks prime factor counts against a behavioral predictor.
module tb_prime_factor_count;
  timeunit 1ns;
  timeprecision 1ps;

  import pfc_pkg::*;

  localparam int unsigned VALUE_BITS = 20;
  localparam logic [VALUE_BITS-1:0] VALUE_ALL_ONES = '1;
  // Start the long receiver hold-off once this many results have been taken.
  localparam int unsigned LONG_HOLD_AFTER = 30;
  localparam int unsigned LONG_HOLD_CYCLES = 50000;
  // Quiet cycles after the last result to catch anything spurious.
  localparam int unsigned TAIL_CYCLES = 200;

  // One pending request: the value, and whether to drain the block before it.
  typedef struct {
    logic [VALUE_BITS-1:0] value;
    bit                    drain_first;
  } count_req_t;

  // One outstanding answer: the value it came from and the count it must carry.
  typedef struct {
    logic [VALUE_BITS-1:0] value;
    logic [COUNT_BITS-1:0] count;
  } factor_count_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [VALUE_BITS-1:0] in_value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [COUNT_BITS-1:0] out_factor_count;

  count_req_t    req_q[$];    // requests not yet offered
  factor_count_t count_q[$];  // counts owed by the block, oldest first

  bit          req_taken = 1'b0;  // the offered request went in at the last edge
  int unsigned gap_left = 0;      // sender idle cycles before the next request
  int unsigned hold_left = 0;     // receiver stall cycles left
  int unsigned calm_left = 0;     // receiver cycles with no stall at all
  bit          long_hold_done = 1'b0;
  int unsigned reqs_sent = 0;
  int unsigned results_seen = 0;
  int unsigned errors = 0;
  int unsigned n_small = 0;
  int unsigned n_smooth = 0;
  int unsigned n_wide = 0;

  prime_factor_count #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_factor_count (out_factor_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Count prime factors with multiplicity by trying every divisor from 2 up.
  // A composite divisor never divides, since its primes are already gone.
  // Stop once divisor squared passes the remainder; a leftover above one
  // is one more prime. Saturate at the ceiling of the count field.
  function automatic logic [COUNT_BITS-1:0] omega_of(input logic [VALUE_BITS-1:0] v);
    longint unsigned rem;
    longint unsigned div;
    logic [COUNT_BITS-1:0] n;
    rem = v;
    div = 2;
    n = '0;
    if (rem > 1) begin
      while (div * div <= rem) begin
        while (rem % div == 0) begin
          rem = rem / div;
          if (n < COUNT_MAX) n++;
        end
        div++;
      end
      if (rem > 1 && n < COUNT_MAX) n++;
    end
    return n;
  endfunction

  // Print one line per failure and count it.
  task automatic report_mismatch(input string msg);
    errors++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Queue one request for the driver.
  task automatic add_req(input logic [VALUE_BITS-1:0] v, input bit drain = 1'b0);
    count_req_t r;
    r.value = v;
    r.drain_first = drain;
    req_q.push_back(r);
  endtask

  // Build a value from small primes only: it sets high bits yet factors quickly.
  function automatic logic [VALUE_BITS-1:0] smooth_value();
    longint unsigned v;
    longint unsigned p;
    int unsigned k;
    v = 1;
    k = $urandom_range(1, 24);
    repeat (k) begin
      case ($urandom_range(0, 5))
        0: p = 2;
        1: p = 3;
        2: p = 5;
        3: p = 7;
        4: p = 11;
        default: p = 13;
      endcase
      if (v * p <= VALUE_ALL_ONES) v = v * p;
    end
    return v[VALUE_BITS-1:0];
  endfunction

  // Driver: offer requests at the falling edge. Hold valid and the value
  // until the request is taken, then idle for a random gap. Before a request
  // marked for draining, wait until every owed count has come back.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !req_taken) begin
      // hold: request still waiting for in_ready
    end else if (gap_left != 0) begin
      in_valid <= 1'b0;
      in_value <= VALUE_BITS'($urandom());  // drop junk on the bus while idle
      gap_left <= gap_left - 1;
    end else if (req_q.size() != 0 && !(req_q[0].drain_first && count_q.size() != 0)) begin
      int unsigned roll;
      roll = $urandom_range(0, 99);
      in_value <= req_q[0].value;
      in_valid <= 1'b1;
      void'(req_q.pop_front());
      // Mostly back-to-back or short gaps, a few long ones.
      if (roll < 55) gap_left <= 0;
      else if (roll < 90) gap_left <= $urandom_range(1, 4);
      else gap_left <= $urandom_range(20, 400);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: stall out_ready at random. Short stalls are common, long ones
  // rare, and now and then a long calm stretch with no stall at all. Once,
  // after LONG_HOLD_AFTER results, hold off long enough that the block fills
  // and pushes back on its input.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!long_hold_done && results_seen >= LONG_HOLD_AFTER) begin
      long_hold_done <= 1'b1;
      hold_left <= LONG_HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (calm_left != 0) begin
      out_ready <= 1'b1;
      calm_left <= calm_left - 1;
    end else begin
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        out_ready <= 1'b0;
        hold_left <= $urandom_range(1, 6);
      end else if (roll == 3) begin
        out_ready <= 1'b0;
        hold_left <= $urandom_range(100, 1500);
      end else if (roll == 4) begin
        out_ready <= 1'b1;
        calm_left <= $urandom_range(1000, 20000);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: sample both channels at the rising edge. Check a returned count
  // against the oldest owed one before logging a new request, so a request
  // taken at the same edge never pairs with this result.
  always @(posedge clk) begin
    if (!rst_n) begin
      req_taken <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (count_q.size() == 0) begin
          report_mismatch($sformatf("result count=%0d with no request outstanding",
                                    out_factor_count));
        end else begin
          factor_count_t owed;
          owed = count_q.pop_front();
          if (out_factor_count !== owed.count)
            report_mismatch($sformatf("value=%0d factor_count=%0d, predicted %0d",
                                      owed.value, out_factor_count, owed.count));
        end
      end
      req_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        factor_count_t nxt;
        nxt.value = in_value;
        nxt.count = omega_of(in_value);
        count_q.push_back(nxt);
        reqs_sent <= reqs_sent + 1;
      end
    end
  end

  // Build the request list, release reset, then wait for the traffic to drain.
  initial begin
    int unsigned roll;

    // Directed: zero and one, small primes and powers, the widest values,
    // large primes that walk the full divisor range, a prime square at the
    // top of the range, and the highest counts a value of this width allows.
    add_req(0);
    add_req(1);
    add_req(2);
    add_req(3);
    add_req(4);
    add_req(6);
    add_req(9);
    add_req(97);
    add_req(1001);
    add_req(VALUE_ALL_ONES);
    add_req(20'd1048573);   // largest prime below 2**20
    add_req(20'd999983);
    add_req(20'd524287);    // prime, all low bits set
    add_req(20'd1048574);   // two times that prime
    add_req(20'd1042441);   // 1021 squared
    add_req(20'd1046529);   // 1023 squared
    add_req(20'd1000001);
    add_req(20'd524288);    // 2**19, the highest count possible
    add_req(20'd786432);    // 3 * 2**18
    add_req(20'd531441);    // 3**12
    add_req(20'd65536);
    add_req(20'd30030);
    add_req(20'd1);

    // Random: mostly small values so each walk stays short, some built from
    // small primes to cover the high bits cheaply, and a few full-width values.
    for (int i = 0; i < 80; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 68) begin
        add_req(VALUE_BITS'($urandom_range(0, 4095)), i == 45);
        n_small++;
      end else if (roll < 90) begin
        add_req(smooth_value(), i == 45);
        n_smooth++;
      end else begin
        add_req(VALUE_BITS'($urandom()), i == 45);
        n_wide++;
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (req_q.size() != 0 || in_valid || count_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (count_q.size() != 0)
      report_mismatch($sformatf("%0d counts never returned", count_q.size()));

    $display("Covered %0d requests and %0d results: directed edge values, %0d small, %0d smooth,",
             reqs_sent, results_seen, n_small, n_smooth);
    $display("%0d full-width values, one long receiver hold-off and one sender drain pause; %0d errors",
             n_wide, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: the slowest legal run is far shorter than this.
  initial begin
    #300_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/pfc_pkg.sv
rtl/pfc_div.sv
rtl/prime_factor_count.sv
tb/tb_prime_factor_count.sv
